[rtl/core/usc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types and constants for the URL segment type classifier.
// ----------------------------------------------------------------------------
package usc_pkg;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] POS_MAX       = 6'd63;
    localparam logic [POS_W-1:0] ID_LEN        = 6'd22;
    localparam logic [POS_W-1:0] ID_PADDED_LEN = 6'd24;
    localparam logic [POS_W-1:0] UUID_LEN      = 6'd36;
    localparam logic [POS_W-1:0] UUID_DASH0    = 6'd8;
    localparam logic [POS_W-1:0] UUID_DASH1    = 6'd13;
    localparam logic [POS_W-1:0] UUID_DASH2    = 6'd18;
    localparam logic [POS_W-1:0] UUID_DASH3    = 6'd23;

    localparam logic [7:0] CH_EQ    = 8'h3D; // '='
    localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
    localparam logic [7:0] CH_UNDER = 8'h5F; // '_'
    localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
    localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'

    typedef enum logic [2:0] {
        TYPE_INT      = 3'd0,
        TYPE_BASE64ID = 3'd1,
        TYPE_STRING   = 3'd2,
        TYPE_UUID     = 3'd3,
        TYPE_FLOAT    = 3'd4,
        TYPE_GENERIC  = 3'd5
    } ptype_t;

    typedef struct packed {
        logic is_dig;
        logic is_hex;
        logic is_alphanum;
        logic is_minus;
        logic is_plus;
        logic is_dot;
        logic is_eq;
        logic is_under;
    } char_class_t;

    typedef struct packed {
        logic ok_int;
        logic ok_base64id;
        logic ok_string;
        logic ok_uuid;
        logic ok_float;
    } seg_ok_t;

endpackage : usc_pkg
`default_nettype wire

[rtl/core/usc_char_class.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usc_char_class
// C-locale character class decode of one segment byte.
// ----------------------------------------------------------------------------
module usc_char_class (
    input  wire logic [7:0]           char_in,
    output usc_pkg::char_class_t      cls
);
    import usc_pkg::*;

    logic dig, lower, upper, hex_lo, hex_up;

    always_comb
    begin
        dig    = (char_in >= 8'h30) && (char_in <= 8'h39);
        lower  = (char_in >= 8'h61) && (char_in <= 8'h7A);
        upper  = (char_in >= 8'h41) && (char_in <= 8'h5A);
        hex_lo = (char_in >= 8'h61) && (char_in <= 8'h66);
        hex_up = (char_in >= 8'h41) && (char_in <= 8'h46);

        cls.is_dig      = dig;
        cls.is_hex      = dig | hex_lo | hex_up;
        cls.is_alphanum = dig | lower | upper;
        cls.is_minus    = (char_in == CH_MINUS);
        cls.is_plus     = (char_in == CH_PLUS);
        cls.is_dot      = (char_in == CH_DOT);
        cls.is_eq       = (char_in == CH_EQ);
        cls.is_under    = (char_in == CH_UNDER);
    end

endmodule : usc_char_class
`default_nettype wire

[rtl/core/usc_seg_track.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usc_seg_track
// Per-segment scan state; gives the type verdicts for the byte being taken.
// ----------------------------------------------------------------------------
module usc_seg_track (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire usc_pkg::char_class_t cls,
    input  wire logic                 last_char,
    input  wire logic                 segment_empty,
    output usc_pkg::seg_ok_t          seg_ok
);
    import usc_pkg::*;

    logic [POS_W-1:0] position_reg, position_next;
    logic int_ok_reg,    int_ok_next;
    logic int_dig_reg,   int_dig_next;
    logic flt_ok_reg,    flt_ok_next;
    logic flt_dot_reg,   flt_dot_next;
    logic flt_dig_reg,   flt_dig_next;
    logic uuid_ok_reg,   uuid_ok_next;
    logic id_pay_reg,    id_pay_next;
    logic id_pad_reg,    id_pad_next;

    logic sign_lead, dash_pos, seg_end;

    always_comb
    begin
        sign_lead = (position_reg == '0) && (cls.is_plus || cls.is_minus);
        dash_pos  = (position_reg == UUID_DASH0) || (position_reg == UUID_DASH1) ||
                    (position_reg == UUID_DASH2) || (position_reg == UUID_DASH3);

        int_dig_next = int_dig_reg | cls.is_dig;
        int_ok_next  = int_ok_reg & (cls.is_dig | sign_lead);

        flt_dig_next = flt_dig_reg;
        flt_dot_next = flt_dot_reg;
        flt_ok_next  = flt_ok_reg;
        priority if (cls.is_dig)
            flt_dig_next = 1'b1;
        else if (cls.is_dot && !flt_dot_reg)
            flt_dot_next = 1'b1;
        else if (!sign_lead)
            flt_ok_next = 1'b0;

        uuid_ok_next = uuid_ok_reg;
        priority if (dash_pos)
            uuid_ok_next = uuid_ok_reg & cls.is_minus;
        else if (position_reg < UUID_LEN)
            uuid_ok_next = uuid_ok_reg & cls.is_hex;

        id_pay_next = id_pay_reg;
        id_pad_next = id_pad_reg;
        priority if (position_reg < ID_LEN)
            id_pay_next = id_pay_reg & (cls.is_alphanum | cls.is_minus | cls.is_under);
        else if (position_reg < ID_PADDED_LEN)
            id_pad_next = id_pad_reg & cls.is_eq;

        position_next = (position_reg == POS_MAX) ? position_reg
                                                  : position_reg + {{(POS_W-1){1'b0}}, 1'b1};

        // verdicts as of this byte; empty segment accepts only generic
        seg_ok.ok_int      = !segment_empty && int_ok_next && int_dig_next;
        seg_ok.ok_base64id = !segment_empty && id_pay_next &&
                             ((position_next == ID_LEN) ||
                              ((position_next == ID_PADDED_LEN) && id_pad_next));
        seg_ok.ok_string   = !segment_empty;
        seg_ok.ok_uuid     = !segment_empty && uuid_ok_next && (position_next == UUID_LEN);
        seg_ok.ok_float    = !segment_empty && flt_ok_next && flt_dig_next;

        seg_end = segment_empty | last_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            int_ok_reg   <= 1'b1;
            int_dig_reg  <= 1'b0;
            flt_ok_reg   <= 1'b1;
            flt_dot_reg  <= 1'b0;
            flt_dig_reg  <= 1'b0;
            uuid_ok_reg  <= 1'b1;
            id_pay_reg   <= 1'b1;
            id_pad_reg   <= 1'b1;
        end
        else if (step)
        begin
            if (seg_end)
            begin
                position_reg <= '0;
                int_ok_reg   <= 1'b1;
                int_dig_reg  <= 1'b0;
                flt_ok_reg   <= 1'b1;
                flt_dot_reg  <= 1'b0;
                flt_dig_reg  <= 1'b0;
                uuid_ok_reg  <= 1'b1;
                id_pay_reg   <= 1'b1;
                id_pad_reg   <= 1'b1;
            end
            else
            begin
                position_reg <= position_next;
                int_ok_reg   <= int_ok_next;
                int_dig_reg  <= int_dig_next;
                flt_ok_reg   <= flt_ok_next;
                flt_dot_reg  <= flt_dot_next;
                flt_dig_reg  <= flt_dig_next;
                uuid_ok_reg  <= uuid_ok_next;
                id_pay_reg   <= id_pay_next;
                id_pad_reg   <= id_pad_next;
            end
        end
    end

endmodule : usc_seg_track
`default_nettype wire

[rtl/core/url_segment_type_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: a segment's last byte is taken into the input register, then its
//   verdicts are written into the result register.
// Throughput: one byte per cycle, set by the single scan stage between the
//   input and result registers; a last byte waits on an undrained result.
// Reset: rst_n clears all scan state, both valid flags and sets enabled_reg
//   to 63; no clearing pass.
// ----------------------------------------------------------------------------
// url_segment_type_classifier
// Classifies a URL path segment, streamed one byte per item, into parameter
// types and picks the first enabled match in priority order.
// ----------------------------------------------------------------------------
module url_segment_type_classifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_in,
    input  wire logic        last_char,
    input  wire logic        segment_empty,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             ok_int,
    output logic             ok_base64id,
    output logic             ok_string,
    output logic             ok_uuid,
    output logic             ok_float,
    output logic             any_match,
    output logic [2:0]       match_type
);
    import usc_pkg::*;

    // type mask register
    logic [5:0] enabled_reg;

    // input register stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       s1_empty_reg;

    // result register stage
    logic       res_valid_reg, res_valid_next;
    seg_ok_t    res_ok_reg;
    logic       res_any_reg;
    ptype_t     res_type_reg;

    char_class_t cls;
    seg_ok_t     seg_ok;
    logic        s1_ends, res_free, s1_go, in_take;
    logic [5:0]  hit;
    logic        sel_any;
    ptype_t      sel_type;

    usc_char_class u_class (
        .char_in (s1_char_reg),
        .cls     (cls)
    );

    usc_seg_track u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_go),
        .cls           (cls),
        .last_char     (s1_last_reg),
        .segment_empty (s1_empty_reg),
        .seg_ok        (seg_ok)
    );

    // Stage-1 item moves on at once if it ends nothing; an ending item
    // needs a free result slot. The result slot is free when empty or
    // being drained this cycle, so bytes flow back to back.
    always_comb
    begin
        s1_ends  = s1_last_reg | s1_empty_reg;
        res_free = !res_valid_reg || out_ready;
        s1_go    = s1_valid_reg && (!s1_ends || res_free);
        in_ready = !s1_valid_reg || s1_go;
        in_take  = in_valid && in_ready;

        s1_valid_next  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        res_valid_next = (s1_go && s1_ends) ? 1'b1
                       : (out_ready ? 1'b0 : res_valid_reg);
    end

    // First enabled accepting type; generic always accepts.
    always_comb
    begin
        hit = enabled_reg & {1'b1, seg_ok.ok_float, seg_ok.ok_uuid,
                             seg_ok.ok_string, seg_ok.ok_base64id, seg_ok.ok_int};
        sel_any  = |hit;
        sel_type = TYPE_INT;
        priority if (hit[0]) sel_type = TYPE_INT;
        else if (hit[1])     sel_type = TYPE_BASE64ID;
        else if (hit[2])     sel_type = TYPE_STRING;
        else if (hit[3])     sel_type = TYPE_UUID;
        else if (hit[4])     sel_type = TYPE_FLOAT;
        else if (hit[5])     sel_type = TYPE_GENERIC;
        else                 sel_type = TYPE_INT;   // nothing enabled accepts
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 6'd63;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                enabled_reg <= cfg_wr_data;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg  <= char_in;
            s1_last_reg  <= last_char;
            s1_empty_reg <= segment_empty;
        end
        if (s1_go && s1_ends)
        begin
            res_ok_reg   <= seg_ok;
            res_any_reg  <= sel_any;
            res_type_reg <= sel_type;
        end
    end

    assign out_valid   = res_valid_reg;
    assign ok_int      = res_ok_reg.ok_int;
    assign ok_base64id = res_ok_reg.ok_base64id;
    assign ok_string   = res_ok_reg.ok_string;
    assign ok_uuid     = res_ok_reg.ok_uuid;
    assign ok_float    = res_ok_reg.ok_float;
    assign any_match   = res_any_reg;
    assign match_type  = res_type_reg;

    // No match reports type code int.
    a_nomatch_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !any_match) |-> (match_type == TYPE_INT))
        else $error("match_type nonzero without a match");

    // Only an empty segment fails the string check, and then all else fails.
    a_empty_all_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok_string) |-> (!ok_int && !ok_base64id && !ok_uuid && !ok_float))
        else $error("type accepted on empty segment");

    // Every integer is also a float.
    a_int_is_float: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ok_int) |-> ok_float)
        else $error("int accepted but float rejected");

    // UUID carries hyphens and 36 chars, so neither int nor id can match.
    a_uuid_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ok_uuid) |-> (!ok_int && !ok_base64id))
        else $error("uuid overlaps int or id");

endmodule : url_segment_type_classifier
`default_nettype wire
